### rtl/gpt_pkg.sv
// Shared types and constants for the gaze pan/tilt slew limiter.
// Holds opcodes, register indexes, reset values and the CORDIC arctangent table.
// No dependencies.
package gpt_pkg;

    // Default field widths
    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 24;

    // Configuration register widths and reset values
    localparam int HEIGHT_W  = 12;
    localparam int STEP_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 12'd1100;
    localparam logic [STEP_W-1:0]   PAN_STEP_RST = 15'd1043;
    localparam logic [STEP_W-1:0]   TILT_STEP_RST = 15'd730;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_HT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TILT = 2'd2;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_MEAS  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    // CORDIC datapath: 64-bit vectors, 2^32 angle units per turn
    localparam int CW          = 64;
    localparam int ZW          = 32;
    localparam int ITER_W      = 5;
    localparam int NORM_TOP    = 57;
    localparam int NORM_COARSE = 50;
    localparam int NORM_BIG    = 7;
    localparam logic [ZW-1:0] Z_HALF   = 32'h8000_0000;
    localparam logic [15:0]   INV_GAIN = 16'd39797;

    function automatic logic [ZW-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/gaze_pan_tilt_slew_limiter.sv
// Top level of the gaze pan/tilt slew limiter: configuration registers,
// request queue, front end, back end and result queue.
// Depends on gpt_pkg, gpt_fifo, gpt_front and gpt_back.
//
// Usage: requests enter through push/full; a request is taken at a clock edge
// with push high and full low. Results leave through empty/pop: the oldest
// result sits on the o_ ports while empty is low and is taken with pop high.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while idle.
// A taken request waits in the request queue until the back end takes it.
// Measured-pose, start and stop requests are executed as the back end takes
// them, without leaving idle. A tick runs normalizing shifts, two 32-iteration
// CORDIC passes on the shared unit with a load and a hand-off step each, and
// the magnitude gain correction in S_HD1 and S_HD2. A gaze point exactly at
// the head pivot gives both CORDIC passes a zero vector, so they skip their
// iterations. A result shows on the o_ ports the cycle after it is queued,
// if no older result waits. Two requests queue ahead of the back end, so new
// requests are taken while a tick is in progress. When the receiver stalls,
// results collect in a two-entry queue and the back end holds until room is
// free; full then rises once the request queue fills.
// Reset clears the goal, the measured pose and the commands to zero and
// loads the default register values; no clearing pass is needed.
module gaze_pan_tilt_slew_limiter #(
    parameter int ANGLE_BITS = gpt_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = gpt_pkg::POS_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpt_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_opcode,
    input  logic signed [POS_BITS-1:0]     i_robot_x,
    input  logic signed [POS_BITS-1:0]     i_robot_y,
    input  logic signed [ANGLE_BITS-1:0]   i_robot_yaw,
    input  logic signed [POS_BITS-1:0]     i_gaze_x,
    input  logic signed [POS_BITS-1:0]     i_gaze_y,
    input  logic signed [POS_BITS-1:0]     i_gaze_z,
    input  logic                           i_lookup_ok,
    input  logic signed [ANGLE_BITS-1:0]   i_pan_value,
    input  logic signed [ANGLE_BITS-1:0]   i_tilt_value,
    input  logic                           i_restore_enable,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [ANGLE_BITS-1:0]   o_cmd_pan_out,
    output logic signed [ANGLE_BITS-1:0]   o_cmd_tilt_out,
    output logic                           o_is_restore
);
    import gpt_pkg::*;

    localparam int CMD_W = 4 + 3 * ANGLE_BITS + 4 * (POS_BITS + 1);
    localparam int RES_W = 2 * ANGLE_BITS + 1;
    localparam int QDEPTH = 2;

    logic [HEIGHT_W-1:0] r_pivot_ht;
    logic [STEP_W-1:0]   r_max_pan, r_max_tilt;
    logic                q_push, q_full, q_pop, q_empty, res_push, res_full;
    logic [CMD_W-1:0]    q_wdata, q_rdata;
    logic [RES_W-1:0]    res_wdata, res_rdata;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_ht <= HEIGHT_RST;
            r_max_pan  <= PAN_STEP_RST;
            r_max_tilt <= TILT_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIVOT_HT: r_pivot_ht <= i_cfg_wdata[HEIGHT_W-1:0];
                CFG_MAX_PAN:  r_max_pan  <= i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_TILT: r_max_tilt <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    gpt_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_robot_x        (i_robot_x),
        .i_robot_y        (i_robot_y),
        .i_robot_yaw      (i_robot_yaw),
        .i_gaze_x         (i_gaze_x),
        .i_gaze_y         (i_gaze_y),
        .i_gaze_z         (i_gaze_z),
        .i_lookup_ok      (i_lookup_ok),
        .i_pan_value      (i_pan_value),
        .i_tilt_value     (i_tilt_value),
        .i_restore_enable (i_restore_enable),
        .i_pivot_ht       (r_pivot_ht),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_data         (q_wdata)
    );

    gpt_fifo #(
        .W     (CMD_W),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    gpt_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS),
        .CMD_W      (CMD_W),
        .RES_W      (RES_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_pan  (r_max_pan),
        .i_max_tilt (r_max_tilt),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_wdata)
    );

    gpt_fifo #(
        .W     (RES_W),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    // Split the oldest result onto the output ports
    assign o_cmd_pan_out  = res_rdata[RES_W-1 -: ANGLE_BITS];
    assign o_cmd_tilt_out = res_rdata[ANGLE_BITS:1];
    assign o_is_restore   = res_rdata[0];
endmodule

### rtl/gpt_fifo.sv
// Small register queue used between the front, the back and the result port.
// Depends on nothing but its parameters.
module gpt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store written entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### rtl/gpt_front.sv
// Front end: accepts requests, forms position differences, drops ticks whose pose lookup failed.
// Depends on gpt_pkg.
module gpt_front #(
    parameter int ANGLE_BITS = gpt_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = gpt_pkg::POS_BITS_DEF,
    parameter int CMD_W      = 4 + 3 * ANGLE_BITS + 4 * (POS_BITS + 1)
) (
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_opcode,
    input  logic signed [POS_BITS-1:0]    i_robot_x,
    input  logic signed [POS_BITS-1:0]    i_robot_y,
    input  logic signed [ANGLE_BITS-1:0]  i_robot_yaw,
    input  logic signed [POS_BITS-1:0]    i_gaze_x,
    input  logic signed [POS_BITS-1:0]    i_gaze_y,
    input  logic signed [POS_BITS-1:0]    i_gaze_z,
    input  logic                          i_lookup_ok,
    input  logic signed [ANGLE_BITS-1:0]  i_pan_value,
    input  logic signed [ANGLE_BITS-1:0]  i_tilt_value,
    input  logic                          i_restore_enable,
    input  logic [gpt_pkg::HEIGHT_W-1:0]  i_pivot_ht,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [CMD_W-1:0]              o_q_data
);
    import gpt_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int DW = POS_BITS + 1;

    typedef struct packed {
        t_opcode        op;
        logic           restore;
        logic           spare;
        logic [AB-1:0]  yaw;
        logic [AB-1:0]  pan;
        logic [AB-1:0]  tilt;
        logic [DW-1:0]  dx;
        logic [DW-1:0]  dy;
        logic [DW-1:0]  dz;
        logic [DW-1:0]  mag;
    } t_cmd;

    t_cmd          cmd;
    logic [DW-1:0] dx, dy, dz, ax, ay, az, mxy;
    logic          skip;

    // Form differences and the largest magnitude
    always_comb begin
        dx  = {i_gaze_x[POS_BITS-1], i_gaze_x} - {i_robot_x[POS_BITS-1], i_robot_x};
        dy  = {i_gaze_y[POS_BITS-1], i_gaze_y} - {i_robot_y[POS_BITS-1], i_robot_y};
        dz  = {i_gaze_z[POS_BITS-1], i_gaze_z} - DW'(i_pivot_ht);
        ax  = dx[DW-1] ? -dx : dx;
        ay  = dy[DW-1] ? -dy : dy;
        az  = dz[DW-1] ? -dz : dz;
        mxy = (ay > ax) ? ay : ax;
    end

    // Pack the request
    always_comb begin
        cmd.op      = t_opcode'(i_opcode);
        cmd.restore = i_restore_enable;
        cmd.spare   = 1'b0;
        cmd.yaw     = i_robot_yaw;
        cmd.pan     = i_pan_value;
        cmd.tilt    = i_tilt_value;
        cmd.dx      = dx;
        cmd.dy      = dy;
        cmd.dz      = dz;
        cmd.mag     = (az > mxy) ? az : mxy;
    end

    // Drop ticks whose pose lookup failed
    assign skip     = (t_opcode'(i_opcode) == OP_TICK) && !i_lookup_ok;
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full && !skip;
    assign o_q_data = cmd;
endmodule

### rtl/gpt_cordic.sv
// Vectoring CORDIC unit: one micro-rotation per cycle, 32 iterations.
// Depends on gpt_pkg for the arctangent table and datapath widths.
module gpt_cordic (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [gpt_pkg::CW-1:0] i_x,
    input  logic signed [gpt_pkg::CW-1:0] i_y,
    output logic                         o_done,
    output logic [gpt_pkg::ZW-1:0]       o_z,
    output logic [gpt_pkg::CW-1:0]       o_mag
);
    import gpt_pkg::*;

    logic signed [CW-1:0] r_x, r_y, xs, ys;
    logic [ZW-1:0]        r_z;
    logic [ITER_W-1:0]    r_i;
    logic                 r_busy, r_done;

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign o_done = r_done;
    assign o_z    = r_z;
    assign o_mag  = r_x;

    // Load the vector, fold the left half plane, then rotate toward the x axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_x    <= '0;
                    r_y    <= '0;
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else if (i_x < 0) begin
                    r_x    <= -i_x;
                    r_y    <= -i_y;
                    r_z    <= Z_HALF;
                    r_busy <= 1'b1;
                end else begin
                    r_x    <= i_x;
                    r_y    <= i_y;
                    r_z    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_lut(r_i);
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_lut(r_i);
                end
                r_i <= r_i + 1'b1;
                if (r_i == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### rtl/gpt_back.sv
// Back end: holds the gaze state, executes queued requests, runs the tick math.
// Depends on gpt_pkg and gpt_cordic.
module gpt_back #(
    parameter int ANGLE_BITS = gpt_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = gpt_pkg::POS_BITS_DEF,
    parameter int CMD_W      = 4 + 3 * ANGLE_BITS + 4 * (POS_BITS + 1),
    parameter int RES_W      = 2 * ANGLE_BITS + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gpt_pkg::STEP_W-1:0]  i_max_pan,
    input  logic [gpt_pkg::STEP_W-1:0]  i_max_tilt,
    input  logic                        i_q_empty,
    input  logic [CMD_W-1:0]            i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_res_full,
    output logic                        o_res_push,
    output logic [RES_W-1:0]            o_res_data
);
    import gpt_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int DW = POS_BITS + 1;
    localparam int EW = (AB + 2 > STEP_W + 2) ? AB + 2 : STEP_W + 2;

    typedef struct packed {
        t_opcode        op;
        logic           restore;
        logic           spare;
        logic [AB-1:0]  yaw;
        logic [AB-1:0]  pan;
        logic [AB-1:0]  tilt;
        logic [DW-1:0]  dx;
        logic [DW-1:0]  dy;
        logic [DW-1:0]  dz;
        logic [DW-1:0]  mag;
    } t_cmd;

    typedef struct packed {
        logic [AB-1:0] pan;
        logic [AB-1:0] tilt;
        logic          restore;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE, S_NORM, S_PAN, S_HD1, S_HD2, S_TILT, S_UPD
    } t_state;

    t_state               r_state;
    t_cmd                 cmd;
    t_res                 res;
    logic [AB-1:0]        r_meas_pan, r_meas_tilt, r_cmd_pan, r_tilt_cmd, r_yaw;
    logic                 r_meas_valid, r_goal;
    logic signed [CW-1:0] r_dx, r_dy, r_dz, r_cx, r_cy;
    logic [CW-1:0]        r_m, r_hi;
    logic [31:0]          r_lo;
    logic [ZW-1:0]        r_zp;
    logic                 r_cstart;
    logic                 take, c_done;
    logic [ZW-1:0]        c_z;
    logic [CW-1:0]        c_mag;

    logic [ZW:0]          sum_p, sum_t;
    logic [AB-1:0]        tp, err_p, tt, n_cmd_pan, n_tilt_cmd;
    logic signed [EW-1:0] ep, et, lp, lt, sp, st;

    assign cmd  = t_cmd'(i_q_data);
    assign take = (r_state == S_IDLE) && !i_q_empty && !i_res_full;
    assign o_q_pop = take;

    gpt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .o_done  (c_done),
        .o_z     (c_z),
        .o_mag   (c_mag)
    );

    // Round both angles and step the commands toward the targets
    always_comb begin
        sum_p = {1'b0, r_zp} + ((ZW+1)'(1) << (ZW - 1 - AB));
        sum_t = {1'b0, c_z} + ((ZW+1)'(1) << (ZW - 1 - AB));
        tp    = sum_p[ZW-1 -: AB] - r_yaw;
        err_p = tp - r_cmd_pan;
        tt    = sum_t[ZW-1 -: AB];
        ep    = EW'(signed'(err_p));
        et    = EW'(signed'(tt)) - EW'(signed'(r_tilt_cmd));
        lp    = EW'(i_max_pan);
        lt    = EW'(i_max_tilt);
        sp    = (ep > lp) ? lp : ((ep < -lp) ? -lp : ep);
        st    = (et > lt) ? lt : ((et < -lt) ? -lt : et);
        n_cmd_pan  = r_cmd_pan + sp[AB-1:0];
        n_tilt_cmd = r_tilt_cmd + st[AB-1:0];
    end

    // Choose the result: restore pose on stop, new commands on tick
    always_comb begin
        if (r_state == S_UPD) begin
            res.pan     = n_cmd_pan;
            res.tilt    = n_tilt_cmd;
            res.restore = 1'b0;
            o_res_push  = c_done;
        end else begin
            res.pan     = cmd.pan;
            res.tilt    = cmd.tilt;
            res.restore = 1'b1;
            o_res_push  = take && (cmd.op == OP_STOP) && r_goal && cmd.restore;
        end
        o_res_data = res;
    end

    // Sequence requests through normalize, two CORDIC passes with the gain correction between them, and the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_meas_pan   <= '0;
            r_meas_tilt  <= '0;
            r_meas_valid <= 1'b0;
            r_cmd_pan    <= '0;
            r_tilt_cmd   <= '0;
            r_goal       <= 1'b0;
            r_cstart     <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        unique case (cmd.op)
                            OP_MEAS: begin
                                r_meas_pan   <= cmd.pan;
                                r_meas_tilt  <= cmd.tilt;
                                r_meas_valid <= 1'b1;
                            end
                            OP_START: begin
                                r_goal     <= 1'b1;
                                r_cmd_pan  <= r_meas_valid ? r_meas_pan : '0;
                                r_tilt_cmd <= r_meas_valid ? r_meas_tilt : '0;
                            end
                            OP_STOP: begin
                                r_goal <= 1'b0;
                            end
                            OP_TICK: begin
                                if (r_goal) begin
                                    r_dx    <= CW'(signed'(cmd.dx));
                                    r_dy    <= CW'(signed'(cmd.dy));
                                    r_dz    <= CW'(signed'(cmd.dz));
                                    r_m     <= CW'(cmd.mag);
                                    r_yaw   <= cmd.yaw;
                                    r_state <= S_NORM;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_NORM: begin
                    if (r_m == '0 || r_m[CW-1:NORM_TOP] != '0) begin
                        r_cx     <= r_dx;
                        r_cy     <= r_dy;
                        r_cstart <= 1'b1;
                        r_state  <= S_PAN;
                    end else if (r_m[CW-1:NORM_COARSE] == '0) begin
                        r_m  <= r_m << NORM_BIG;
                        r_dx <= r_dx <<< NORM_BIG;
                        r_dy <= r_dy <<< NORM_BIG;
                        r_dz <= r_dz <<< NORM_BIG;
                    end else begin
                        r_m  <= r_m << 1;
                        r_dx <= r_dx <<< 1;
                        r_dy <= r_dy <<< 1;
                        r_dz <= r_dz <<< 1;
                    end
                end
                S_PAN: begin
                    if (c_done) begin
                        r_zp    <= c_z;
                        r_state <= S_HD1;
                    end
                end
                S_HD1: begin
                    r_hi    <= CW'(c_mag[CW-1:16]) * CW'(INV_GAIN);
                    r_lo    <= c_mag[15:0] * INV_GAIN;
                    r_state <= S_HD2;
                end
                S_HD2: begin
                    r_cx     <= signed'(r_hi + CW'(r_lo[31:16]));
                    r_cy     <= r_dz;
                    r_cstart <= 1'b1;
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    if (c_done) begin
                        r_cmd_pan  <= n_cmd_pan;
                        r_tilt_cmd <= n_tilt_cmd;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
